@@ rtl/core/etsr_pkg.sv @@
// ----------------------------------------------------------------------------
// etsr_pkg: shared types and constants for the echo time smoothing ranger
// Request and result payload structs, request codes, register map and the
// fixed-point constants of the distance filter.
// ----------------------------------------------------------------------------
package etsr_pkg;

    // request codes
    localparam logic [1:0] REQ_TRIGGER = 2'd0;
    localparam logic [1:0] REQ_ECHO    = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // result kinds
    localparam logic RES_PULSE    = 1'b0;
    localparam logic RES_DISTANCE = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TOP_COUNT    = 2'd0;
    localparam logic [1:0] REG_WRAP_AT_TOP  = 2'd1;
    localparam logic [1:0] REG_SAMPLES_PER  = 2'd2;

    localparam logic [15:0] TOP_COUNT_RST   = 16'hFFFF;
    localparam logic [5:0]  SAMPLES_PER_RST = 6'd10;

    // largest distance: 65535 / 12
    localparam logic [12:0] DIST_MAX = 13'd5461;

    // ticks / 12 as (ticks * 43691) >> 19, exact for 16-bit ticks
    localparam logic [31:0] RECIP_12      = 32'd43691;
    localparam int          RECIP_12_SHR  = 19;

    // filter weights, out of 1000
    localparam logic [22:0] ACC_WEIGHT    = 23'd700;
    localparam logic [22:0] SAMPLE_WEIGHT = 23'd300;

    // n / 1000 as ((n >> 3) * 1073742) >> 27, exact for n < 2**23
    localparam logic [40:0] RECIP_125     = 41'd1073742;
    localparam int          RECIP_125_SHR = 27;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] timer_count;
        logic [3:0]  sector;
    } req_t;

    typedef struct packed {
        logic        res_kind;
        logic [12:0] distance;
        logic [3:0]  sector_out;
    } res_t;

endpackage

@@ rtl/core/etsr_filter.sv @@
// ----------------------------------------------------------------------------
// etsr_filter: exponential smoothing update
// acc_next = (acc * 700 + sample * 300) / 1000, truncating.
// ----------------------------------------------------------------------------
module etsr_filter
    import etsr_pkg::*;
(
    input  logic [12:0] acc,
    input  logic [12:0] sample,
    output logic [12:0] acc_next
);

    logic [22:0] weighted_sum;
    logic [19:0] sum_div8;
    logic [40:0] quot_wide;

    // constant weights: shift-add, sum stays below 2**23
    assign weighted_sum = 23'(acc) * ACC_WEIGHT + 23'(sample) * SAMPLE_WEIGHT;

    // divide by 8, then by 125 through the reciprocal
    assign sum_div8  = weighted_sum[22:3];
    assign quot_wide = 41'(sum_div8) * RECIP_125;

    // quotient never exceeds 8191, 13 bits hold it
    assign acc_next = quot_wide[RECIP_125_SHR +: 13];

endmodule

@@ rtl/core/echo_time_smoothing_ranger.sv @@
// ----------------------------------------------------------------------------
// echo_time_smoothing_ranger: ultrasonic echo ranging with distance smoothing
// Request channel takes trigger, echo and sample tick events; the result
// channel reports trigger pulses and smoothed distances.
// ----------------------------------------------------------------------------
// Usage:
//   req / req_valid / req_stall : one event per request. Trigger (armed only)
//     stamps the start time, echo measures travel time and latches the sector,
//     tick folds travel/12 mm into the filter or, once samples_per_result
//     samples are in, reports the smoothed distance and clears the filter.
//   res / res_valid / res_stall : at most one result per request.
//   APB port : top_count (0x0), wrap_at_top (0x4), samples_per_result (0x8).
//     Write only while no request is in flight. pready is tied high.
// Timing:
//   A request is held in the stage register, where it reads and
//   updates the ranging state; its result lands in the output register at
//   the same edge, so a request passes through the stage register and its
//   result then through the output register. One request per cycle is
//   sustained while the result side does not stall: the stage register is
//   the only place the state is read and written.
// Reset clears all state, arms the trigger and loads register defaults.
// A stalled result holds in the output register; the stage keeps taking
// requests that give no result, and stalls the request side when it holds
// a request with a result to post.
// ----------------------------------------------------------------------------
module echo_time_smoothing_ranger
    import etsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  req_t        req,
    input  logic        req_valid,
    output logic        req_stall,

    output res_t        res,
    output logic        res_valid,
    input  logic        res_stall,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] top_count_reg;
    logic        wrap_at_top_reg;
    logic [5:0]  samples_per_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg   <= TOP_COUNT_RST;
            wrap_at_top_reg <= 1'b0;
            samples_per_reg <= SAMPLES_PER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TOP_COUNT:   top_count_reg   <= pwdata[15:0];
                REG_WRAP_AT_TOP: wrap_at_top_reg <= pwdata[0];
                REG_SAMPLES_PER: samples_per_reg <= pwdata[5:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_TOP_COUNT:   prdata = {16'd0, top_count_reg};
            REG_WRAP_AT_TOP: prdata = {31'd0, wrap_at_top_reg};
            REG_SAMPLES_PER: prdata = {26'd0, samples_per_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage register
    // ------------------------------------------------------------------
    logic stg_valid_reg, stg_valid_next;
    req_t stg_req_reg;
    logic req_take;
    logic advance;
    logic has_result;

    assign req_stall = stg_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (req_take)
            stg_valid_next = 1'b1;
        else if (advance)
            stg_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else
            stg_valid_reg <= stg_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            stg_req_reg <= req;
    end

    // ------------------------------------------------------------------
    // ranging state
    // ------------------------------------------------------------------
    logic [15:0] start_stamp_reg, start_stamp_next;
    logic [12:0] sample_mm_reg, sample_mm_next;   // travel ticks / 12
    logic        armed_reg, armed_next;
    logic [3:0]  sector_reg, sector_next;
    logic [12:0] acc_reg, acc_next;
    logic [5:0]  count_reg, count_next;

    logic [15:0] gap;
    logic [15:0] travel;
    logic [31:0] travel_scaled;
    logic [12:0] acc_fold;
    logic        tick_emit;
    res_t        res_calc;

    // travel time; finish before start wraps from top or from all ones
    assign gap = start_stamp_reg - stg_req_reg.timer_count;

    always_comb
    begin
        if (start_stamp_reg > stg_req_reg.timer_count)
            travel = wrap_at_top_reg ? (top_count_reg - gap) : ~gap;
        else
            travel = stg_req_reg.timer_count - start_stamp_reg;
    end

    assign travel_scaled = 32'(travel) * RECIP_12;

    etsr_filter u_filter (
        .acc      (acc_reg),
        .sample   (sample_mm_reg),
        .acc_next (acc_fold)
    );

    assign tick_emit = (count_reg >= samples_per_reg);

    always_comb
    begin
        start_stamp_next = start_stamp_reg;
        sample_mm_next   = sample_mm_reg;
        armed_next       = armed_reg;
        sector_next      = sector_reg;
        acc_next         = acc_reg;
        count_next       = count_reg;
        has_result       = 1'b0;
        res_calc         = '{res_kind: RES_PULSE, distance: 13'd0, sector_out: sector_reg};

        case (stg_req_reg.req_type)
            REQ_TRIGGER:
            begin
                if (armed_reg)
                begin
                    start_stamp_next = stg_req_reg.timer_count;
                    armed_next       = 1'b0;
                    has_result       = 1'b1;
                end
            end
            REQ_ECHO:
            begin
                sample_mm_next = travel_scaled[RECIP_12_SHR +: 13];
                sector_next    = stg_req_reg.sector;
                armed_next     = 1'b1;
            end
            REQ_TICK:
            begin
                if (tick_emit)
                begin
                    has_result        = 1'b1;
                    res_calc.res_kind = RES_DISTANCE;
                    res_calc.distance = acc_reg;
                    acc_next          = 13'd0;
                    count_next        = 6'd0;
                end
                else
                begin
                    acc_next   = acc_fold;
                    count_next = count_reg + 6'd1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    logic out_free;

    assign out_free = !out_valid_reg || !res_stall;
    assign advance  = stg_valid_reg && (!has_result || out_free);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && has_result)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !res_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            start_stamp_reg <= 16'd0;
            sample_mm_reg   <= 13'd0;
            armed_reg       <= 1'b1;
            sector_reg      <= 4'd0;
            acc_reg         <= 13'd0;
            count_reg       <= 6'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                start_stamp_reg <= start_stamp_next;
                sample_mm_reg   <= sample_mm_next;
                armed_reg       <= armed_next;
                sector_reg      <= sector_next;
                acc_reg         <= acc_next;
                count_reg       <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_res_reg <= res_calc;
    end

    assign res       = out_res_reg;
    assign res_valid = out_valid_reg;

`ifndef SYNTH
    // stall is only raised while the stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> stg_valid_reg)
        else $error("request stalled with empty stage");

    // a taken trigger disarms, an echo re-arms
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_req_reg.req_type == REQ_TRIGGER && armed_reg |=> !armed_reg)
        else $error("trigger did not disarm");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_req_reg.req_type == REQ_ECHO |=> armed_reg)
        else $error("echo did not re-arm");

    // an emitting tick clears the filter
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_req_reg.req_type == REQ_TICK && tick_emit
        |=> acc_reg == 13'd0 && count_reg == 6'd0 && out_valid_reg)
        else $error("emitting tick did not clear filter");

    // scaled travel and filter stay in distance range
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_mm_reg <= DIST_MAX && acc_reg <= DIST_MAX)
        else $error("distance out of range");
`endif

endmodule
